### src/apdu_dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_dec_pkg
// Shared constants and types for the command APDU decoder.
// ----------------------------------------------------------------------------
package apdu_dec_pkg;

    // byte counter saturates here, above every valid command length
    localparam int unsigned LENGTH_LIMIT = 131071;
    localparam int COUNT_W    = $clog2(LENGTH_LIMIT + 1);
    localparam int DIFF_W     = COUNT_W + 2;
    localparam int HEADER_LEN = 7;
    localparam int TAIL_LEN   = 3;
    localparam int RESULT_W   = 77;
    localparam int TDATA_W    = ((RESULT_W + 7) / 8) * 8;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_WRONG_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_CONDITIONS   = 2'd2;

    localparam logic [5:0] CASE_NONE   = 6'h00;
    localparam logic [5:0] CASE_1      = 6'h01;
    localparam logic [5:0] CASE_2S     = 6'h02;
    localparam logic [5:0] CASE_3S     = 6'h03;
    localparam logic [5:0] CASE_4S     = 6'h04;
    localparam logic [5:0] CASE_2E     = 6'h12;
    localparam logic [5:0] CASE_3E     = 6'h13;
    localparam logic [5:0] CASE_4E     = 6'h14;
    localparam logic [5:0] CASE_4E_LE3 = 6'h24;

    localparam logic [7:0]  CLA_MASK     = 8'hef;
    localparam logic [16:0] LE_SHORT_MAX = 17'h00100;
    localparam logic [16:0] LE_EXT_MAX   = 17'h10000;
    localparam logic [2:0]  OFFSET_NONE  = 3'd0;
    localparam logic [2:0]  OFFSET_SHORT = 3'd5;
    localparam logic [2:0]  OFFSET_EXT   = 3'd7;

    // decoded command, first field in the highest bits
    typedef struct packed {
        logic [2:0]  data_offset;
        logic        is_extended;
        logic [16:0] expected_length;
        logic [15:0] command_length;
        logic [5:0]  case_code;
        logic [7:0]  param_two;
        logic [7:0]  param_one;
        logic [7:0]  instruction;
        logic [7:0]  class_byte;
        logic [1:0]  status;
    } result_t;

endpackage
`default_nettype wire

### src/apdu_command_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_command_decoder
// Decodes an ISO 7816 command APDU fed one byte per item into header fields,
// case code, Lc, Le and status.
// ----------------------------------------------------------------------------
//  channel | dir | signals                      | item
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast | one command byte, tlast on last
//  m_      | out | m_tvalid m_tready m_tdata    | one decoded command
//
//  one byte accepted per cycle while no stalled result holds back a last byte; the last
//  byte waits in the input register, then decodes into the result register
//  aresetn clears the byte counter, stored bytes and both valid flags
//  a stalled result blocks only a following last byte; other bytes keep flowing
// ----------------------------------------------------------------------------
module apdu_command_decoder
    import apdu_dec_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] byte_value
    input  wire logic               s_tlast,   // last_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [1:0] status, [9:2] class_byte, [17:10] instruction, [25:18] param_one,
    // [33:26] param_two, [39:34] case_code, [55:40] command_length,
    // [72:56] expected_length, [73] is_extended, [76:74] data_offset, zero pad
    output logic [TDATA_W-1:0]      m_tdata
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               out_free;
    logic               consume;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         header_reg [HEADER_LEN];
    logic [7:0]         header_next [HEADER_LEN];
    logic [7:0]         tail_reg [TAIL_LEN];
    logic [7:0]         tail_next [TAIL_LEN];

    logic               out_valid_reg;
    result_t            res_reg, res_next;

    logic [COUNT_W-1:0] len;
    logic [7:0]         b0;
    logic [15:0]        ext_len;
    logic [15:0]        tail_le;
    logic [DIFF_W-1:0]  diff_s;
    logic [DIFF_W-1:0]  diff_e;

    logic [1:0]         status;
    logic [5:0]         kase;
    logic [15:0]        lc;
    logic [16:0]        le;
    logic               extended;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - RESULT_W)'(0), res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // stored bytes including the one being decoded
    always_comb begin
        for (int i = 0; i < HEADER_LEN; i++) begin
            header_next[i] = (count_reg == COUNT_W'(i)) ? in_byte_reg : header_reg[i];
        end
        tail_next[0] = in_byte_reg;
        for (int i = 1; i < TAIL_LEN; i++) begin
            tail_next[i] = tail_reg[i-1];
        end
        len = (count_reg < COUNT_W'(LENGTH_LIMIT)) ? count_reg + COUNT_W'(1) : count_reg;
    end

    assign b0      = header_next[4];
    assign ext_len = {header_next[5], header_next[6]};
    assign tail_le = {tail_next[1], tail_next[0]};
    // len - 5 - b0 and len - 7 - ext, sign bit on top
    assign diff_s  = {2'b00, len} - DIFF_W'(5) - {(DIFF_W - 8)'(0), b0};
    assign diff_e  = {2'b00, len} - DIFF_W'(7) - {(DIFF_W - 16)'(0), ext_len};

    always_comb begin
        status   = STATUS_OK;
        kase     = CASE_NONE;
        lc       = '0;
        le       = '0;
        extended = 1'b0;

        if (len == COUNT_W'(4)) begin
            kase = CASE_1;
        end
        if (len == COUNT_W'(5)) begin
            kase = CASE_2S;
            le   = (b0 != 8'd0) ? {9'd0, b0} : LE_SHORT_MAX;
        end
        if (b0 != 8'd0 && diff_s == DIFF_W'(0)) begin
            kase = CASE_3S;
            lc   = {8'd0, b0};
        end
        if (b0 != 8'd0 && diff_s == DIFF_W'(1)) begin
            kase = CASE_4S;
            lc   = {8'd0, b0};
            le   = (tail_next[0] != 8'd0) ? {9'd0, tail_next[0]} : LE_SHORT_MAX;
        end

        if (len == COUNT_W'(7) && b0 == 8'd0) begin
            kase     = CASE_2E;
            extended = 1'b1;
            le       = (ext_len != 16'd0) ? {1'b0, ext_len} : LE_EXT_MAX;
        end else if (len > COUNT_W'(7) && b0 == 8'd0) begin
            if (diff_e[DIFF_W-1]) begin
                status = STATUS_WRONG_LENGTH;
            end else begin
                if (diff_e == DIFF_W'(0)) begin
                    kase     = CASE_3E;
                    extended = 1'b1;
                    lc       = ext_len;
                end
                if (diff_e == DIFF_W'(2)) begin
                    kase     = CASE_4E;
                    extended = 1'b1;
                    lc       = ext_len;
                    le       = (tail_le != 16'd0) ? {1'b0, tail_le} : LE_EXT_MAX;
                end
                if (diff_e == DIFF_W'(3) && tail_next[2] == 8'd0) begin
                    kase     = CASE_4E_LE3;
                    extended = 1'b1;
                    lc       = ext_len;
                    le       = (tail_le != 16'd0) ? {1'b0, tail_le} : LE_EXT_MAX;
                end
            end
        end else if (len > COUNT_W'(5) && diff_s[DIFF_W-1]) begin
            status = STATUS_WRONG_LENGTH;
        end

        if (status == STATUS_OK && kase == CASE_NONE) begin
            status = STATUS_CONDITIONS;
        end
        if (status != STATUS_OK) begin
            kase     = CASE_NONE;
            lc       = '0;
            le       = '0;
            extended = 1'b0;
        end

        res_next.status          = status;
        res_next.class_byte      = header_next[0] & CLA_MASK;
        res_next.instruction     = header_next[1];
        res_next.param_one       = header_next[2];
        res_next.param_two       = header_next[3];
        res_next.case_code       = kase;
        res_next.command_length  = lc;
        res_next.expected_length = le;
        res_next.is_extended     = extended;
        if (lc == 16'd0) begin
            res_next.data_offset = OFFSET_NONE;
        end else begin
            res_next.data_offset = extended ? OFFSET_EXT : OFFSET_SHORT;
        end
    end

    // state clears after every last byte
    always_comb begin
        count_next = count_reg;
        if (consume && in_last_reg) begin
            count_next = '0;
        end else if (consume) begin
            count_next = len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < HEADER_LEN; i++) header_reg[i] <= '0;
            for (int i = 0; i < TAIL_LEN; i++) tail_reg[i] <= '0;
        end else if (consume) begin
            count_reg <= count_next;
            for (int i = 0; i < HEADER_LEN; i++) begin
                header_reg[i] <= in_last_reg ? 8'd0 : header_next[i];
            end
            for (int i = 0; i < TAIL_LEN; i++) begin
                tail_reg[i] <= in_last_reg ? 8'd0 : tail_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (consume && in_last_reg) begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (count_reg == '0))
        else $error("byte counter not cleared after last byte");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.status != STATUS_OK) |->
        (res_reg.case_code == CASE_NONE && res_reg.expected_length == '0 &&
         res_reg.data_offset == OFFSET_NONE && !res_reg.is_extended))
        else $error("error result carries decoded fields");

    a_offset_lc: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.data_offset != OFFSET_NONE) |->
        (res_reg.command_length != 16'd0))
        else $error("data offset given without command data");

    a_ext_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.is_extended) |-> (res_reg.data_offset != OFFSET_SHORT))
        else $error("extended command with short data offset");
`endif

endmodule
`default_nettype wire

### sim/apdu_command_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdu_command_decoder_tb
// Streams command APDUs into the decoder one byte per item, with random gaps
// on the input and random stalls on the result side. Every decoded command is
// checked field by field against a directed row or a decoder model in this
// bench. A short list of directed commands covers each case code and the
// length errors. Random well-formed, broken and noise commands follow.
// ----------------------------------------------------------------------------
module apdu_command_decoder_tb;
    import apdu_dec_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_BYTES = 210;
    localparam int MIN_COMMANDS = 10;
    localparam int LONG_COMMAND = 1000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        int          len;
        logic [55:0] head;   // bytes 0..6, byte 0 leftmost
        logic [23:0] tail;   // last three bytes, oldest leftmost
        bit          typed;
        result_t     want;
    } dir_row_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    // decoder model state
    logic [16:0] seen_count;
    logic [7:0]  hdr_bytes [HEADER_LEN];
    logic [7:0]  recent_bytes [TAIL_LEN];   // most recent first

    result_t     pending_decodes [$];
    dir_row_t    directed_rows [$];
    int          fail_count    = 0;
    int          decoded_count = 0;
    int unsigned cycle_count   = 0;
    bit          src_calm      = 1'b0;
    bit          src_no_gaps   = 1'b0;
    bit          snk_calm      = 1'b0;
    int          snk_stall     = 0;

    apdu_command_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic clear_model();
        seen_count = '0;
        foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        foreach (recent_bytes[i]) recent_bytes[i] = '0;
    endtask

    // takes one command byte; on the last byte returns the decoded command
    task automatic apdu_absorb(input logic [7:0] b, input logic lst,
                               output bit done, output result_t r);
        int         n, b0, ext, tle, clen, rlen;
        logic [1:0] st;
        logic [5:0] kc;
        bit         ex;
        if (seen_count < HEADER_LEN) hdr_bytes[seen_count] = b;
        recent_bytes[2] = recent_bytes[1];
        recent_bytes[1] = recent_bytes[0];
        recent_bytes[0] = b;
        if (seen_count < LENGTH_LIMIT) seen_count++;
        done = lst;
        r = '0;
        if (!lst) return;

        n    = seen_count;
        b0   = hdr_bytes[4];
        ext  = {hdr_bytes[5], hdr_bytes[6]};
        tle  = {recent_bytes[1], recent_bytes[0]};
        st   = STATUS_OK;
        kc   = CASE_NONE;
        clen = 0;
        rlen = 0;
        ex   = 1'b0;

        if (n == 4) kc = CASE_1;
        if (n == 5) begin
            kc   = CASE_2S;
            rlen = (b0 != 0) ? b0 : LE_SHORT_MAX;
        end
        if (b0 != 0 && n == 5 + b0) begin
            kc   = CASE_3S;
            clen = b0;
        end
        if (b0 != 0 && n == 6 + b0) begin
            kc   = CASE_4S;
            clen = b0;
            rlen = (recent_bytes[0] != 0) ? recent_bytes[0] : LE_SHORT_MAX;
        end

        if (n == 7 && b0 == 0) begin
            kc   = CASE_2E;
            ex   = 1'b1;
            rlen = (ext != 0) ? ext : LE_EXT_MAX;
        end else if (n > 7 && b0 == 0) begin
            if (n - 7 < ext) begin
                st = STATUS_WRONG_LENGTH;
            end else begin
                if (n == 7 + ext) begin
                    kc   = CASE_3E;
                    ex   = 1'b1;
                    clen = ext;
                end
                if (n == 9 + ext) begin
                    kc   = CASE_4E;
                    ex   = 1'b1;
                    clen = ext;
                    rlen = (tle != 0) ? tle : LE_EXT_MAX;
                end
                // extended Le sent as three bytes, leading zero
                if (n == 10 + ext && recent_bytes[2] == 0) begin
                    kc   = CASE_4E_LE3;
                    ex   = 1'b1;
                    clen = ext;
                    rlen = (tle != 0) ? tle : LE_EXT_MAX;
                end
            end
        end else if (n > 5 && n - 5 < b0) begin
            st = STATUS_WRONG_LENGTH;
        end

        if (st == STATUS_OK && kc == CASE_NONE) st = STATUS_CONDITIONS;
        if (st != STATUS_OK) begin
            kc   = CASE_NONE;
            clen = 0;
            rlen = 0;
            ex   = 1'b0;
        end

        r.status          = st;
        r.class_byte      = hdr_bytes[0] & CLA_MASK;
        r.instruction     = hdr_bytes[1];
        r.param_one       = hdr_bytes[2];
        r.param_two       = hdr_bytes[3];
        r.case_code       = kc;
        r.command_length  = 16'(clen);
        r.expected_length = 17'(rlen);
        r.is_extended     = ex;
        r.data_offset     = (clen != 0) ? (ex ? OFFSET_EXT : OFFSET_SHORT) : OFFSET_NONE;
        clear_model();
    endtask

    function automatic result_t res(input logic [1:0] st,
                                    input logic [7:0] cla, ins, p1, p2,
                                    input logic [5:0] kc, input logic [15:0] lc,
                                    input logic [16:0] le, input logic ex,
                                    input logic [2:0] off);
        result_t r;
        r.status          = st;
        r.class_byte      = cla;
        r.instruction     = ins;
        r.param_one       = p1;
        r.param_two       = p2;
        r.case_code       = kc;
        r.command_length  = lc;
        r.expected_length = le;
        r.is_extended     = ex;
        r.data_offset     = off;
        return r;
    endfunction

    function automatic string fmt_decode(input result_t r);
        return $sformatf("st=%0d cla=%h ins=%h p1=%h p2=%h case=%h lc=%h le=%h ext=%0d off=%0d",
                         r.status, r.class_byte, r.instruction, r.param_one,
                         r.param_two, r.case_code, r.command_length,
                         r.expected_length, r.is_extended, r.data_offset);
    endfunction

    task automatic add_row(input int len, input logic [55:0] head,
                           input logic [23:0] tail, input bit typed, input result_t want);
        dir_row_t r;
        r.len   = len;
        r.head  = head;
        r.tail  = tail;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed();
        // lone CLA, and a header cut short
        add_row(1, 56'hFF_00_00_00_00_00_00, 24'h0, 1,
                res(STATUS_CONDITIONS, 8'hEF, 8'h00, 8'h00, 8'h00, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        add_row(3, 56'h00_12_34_00_00_00_00, 24'h0, 1,
                res(STATUS_CONDITIONS, 8'h00, 8'h12, 8'h34, 8'h00, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        // chaining bit dropped from CLA
        add_row(4, 56'h10_A4_04_00_00_00_00, 24'h0, 1,
                res(STATUS_OK, 8'h00, 8'hA4, 8'h04, 8'h00, CASE_1, 0, 0, 0, OFFSET_NONE));
        add_row(5, 56'h00_B0_00_00_00_00_00, 24'h0, 1,
                res(STATUS_OK, 8'h00, 8'hB0, 8'h00, 8'h00, CASE_2S, 0, LE_SHORT_MAX, 0,
                    OFFSET_NONE));
        add_row(5, 56'h80_CA_FF_FF_FF_00_00, 24'h0, 1,
                res(STATUS_OK, 8'h80, 8'hCA, 8'hFF, 8'hFF, CASE_2S, 0, 17'h000FF, 0,
                    OFFSET_NONE));
        add_row(6, 56'h00_D6_00_01_01_5A_00, 24'h0, 1,
                res(STATUS_OK, 8'h00, 8'hD6, 8'h00, 8'h01, CASE_3S, 16'd1, 0, 0,
                    OFFSET_SHORT));
        add_row(261, 56'h00_88_00_00_FF_11_22, 24'h33_44_00, 1,
                res(STATUS_OK, 8'h00, 8'h88, 8'h00, 8'h00, CASE_4S, 16'h00FF,
                    LE_SHORT_MAX, 0, OFFSET_SHORT));
        add_row(260, 56'hFE_E2_12_34_FF_00_00, 24'h0, 0, '0);
        // short body shorter than its Lc calls for
        add_row(8, 56'h00_20_00_81_10_00_00, 24'h01_02_03, 1,
                res(STATUS_WRONG_LENGTH, 8'h00, 8'h20, 8'h00, 8'h81, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        add_row(6, 56'h00_70_00_00_00_00_00, 24'h0, 1,
                res(STATUS_CONDITIONS, 8'h00, 8'h70, 8'h00, 8'h00, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        add_row(7, 56'h00_B0_00_00_00_00_00, 24'h0, 1,
                res(STATUS_OK, 8'h00, 8'hB0, 8'h00, 8'h00, CASE_2E, 0, LE_EXT_MAX, 1,
                    OFFSET_NONE));
        add_row(7, 56'h0C_B0_7F_FF_00_FF_FF, 24'h0, 1,
                res(STATUS_OK, 8'h0C, 8'hB0, 8'h7F, 8'hFF, CASE_2E, 0, 17'h0FFFF, 1,
                    OFFSET_NONE));
        add_row(8, 56'h00_D6_00_00_00_00_01, 24'h00_00_A5, 1,
                res(STATUS_OK, 8'h00, 8'hD6, 8'h00, 8'h00, CASE_3E, 16'd1, 0, 1,
                    OFFSET_EXT));
        add_row(11, 56'h00_2A_9E_9A_00_00_02, 24'h5A_00_00, 1,
                res(STATUS_OK, 8'h00, 8'h2A, 8'h9E, 8'h9A, CASE_4E, 16'd2, LE_EXT_MAX, 1,
                    OFFSET_EXT));
        add_row(11, 56'h00_2A_9E_9A_00_00_01, 24'h00_12_34, 1,
                res(STATUS_OK, 8'h00, 8'h2A, 8'h9E, 8'h9A, CASE_4E_LE3, 16'd1, 17'h01234,
                    1, OFFSET_EXT));
        // three-byte Le without its leading zero
        add_row(11, 56'h00_2A_9E_9A_00_00_01, 24'h01_12_34, 1,
                res(STATUS_CONDITIONS, 8'h00, 8'h2A, 8'h9E, 8'h9A, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        // extended Lc larger than the body
        add_row(9, 56'h00_D6_00_00_00_00_10, 24'h00_11_22, 1,
                res(STATUS_WRONG_LENGTH, 8'h00, 8'hD6, 8'h00, 8'h00, CASE_NONE, 0, 0, 0,
                    OFFSET_NONE));
        // extended Lc of zero followed by a two-byte Le
        add_row(9, 56'hFF_FF_FF_FF_00_00_00, 24'h00_00_2A, 1,
                res(STATUS_OK, 8'hEF, 8'hFF, 8'hFF, 8'hFF, CASE_4E, 0, 17'h0002A, 1,
                    OFFSET_NONE));
        add_row(12, 56'h02_2A_80_86_00_00_03, 24'h77_FF_FF, 0, '0);
    endtask

    task automatic fill_row(input dir_row_t r, ref logic [7:0] cmd [$]);
        cmd.delete();
        for (int i = 0; i < r.len; i++) begin
            if (i < HEADER_LEN) cmd.push_back(r.head[8*(6-i) +: 8]);
            else if (i >= r.len - 3) cmd.push_back(r.tail[8*(r.len-1-i) +: 8]);
            else cmd.push_back(8'($urandom));
        end
    endtask

    task automatic make_random_command(ref logic [7:0] cmd [$]);
        int kind, form, nc, ne;
        cmd.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 12)) cmd.push_back(8'($urandom));
            return;
        end
        repeat (4) cmd.push_back(8'($urandom));
        nc = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(1, 16);
        ne = ($urandom_range(0, 49) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        // broken commands start from a well-formed body
        form = (kind >= 82) ? $urandom_range(20, 75) : kind;
        if (form >= 10 && form < 20) begin
            cmd.push_back(8'($urandom));
        end else if (form >= 20 && form < 50) begin
            cmd.push_back(8'(nc));
            repeat (nc) cmd.push_back(8'($urandom));
            if (form >= 35) cmd.push_back(8'($urandom));
        end else if (form >= 50) begin
            cmd.push_back(8'h00);
            if (form < 58) begin
                repeat (2) cmd.push_back(8'($urandom));
            end else begin
                cmd.push_back(8'(ne >> 8));
                cmd.push_back(8'(ne));
                repeat (ne) cmd.push_back(8'($urandom));
                if (form >= 76) cmd.push_back(8'h00);
                if (form >= 68) repeat (2) cmd.push_back(8'($urandom));
            end
        end
        if (kind >= 82) begin
            if ($urandom_range(0, 1) == 1 && cmd.size() > 1) void'(cmd.pop_back());
            else cmd.push_back(8'($urandom));
        end
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 48);
    endfunction

    // returns at the edge where the byte is taken
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
        gap = src_no_gaps ? 0 : pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_command(ref logic [7:0] cmd [$], input bit typed,
                                input result_t want);
        bit      done;
        result_t model_res;
        src_no_gaps = (cmd.size() > LONG_COMMAND);
        foreach (cmd[i]) begin
            push_byte(cmd[i], i == cmd.size() - 1);
            apdu_absorb(cmd[i], i == cmd.size() - 1, done, model_res);
            if (done) pending_decodes.push_back(typed ? want : model_res);
        end
    endtask

    task automatic check_decode(input result_t got);
        result_t want;
        bit      bad;
        decoded_count++;
        if (pending_decodes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("decode %0d: no command pending, got %s", decoded_count,
                         fmt_decode(got));
            return;
        end
        want = pending_decodes.pop_front();
        bad = (got.status !== want.status) || (got.class_byte !== want.class_byte) ||
              (got.instruction !== want.instruction) ||
              (got.param_one !== want.param_one) || (got.param_two !== want.param_two) ||
              (got.case_code !== want.case_code) ||
              (got.command_length !== want.command_length) ||
              (got.expected_length !== want.expected_length) ||
              (got.is_extended !== want.is_extended) ||
              (got.data_offset !== want.data_offset);
        if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("decode %0d mismatch: exp %s", decoded_count, fmt_decode(want));
                $display("                     got %s", fmt_decode(got));
            end
        end
    endtask

    // result side: random stalls, with calm stretches
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_decode(result_t'(m_tdata[RESULT_W-1:0]));
            if ($urandom_range(0, 63) == 0) snk_calm = !snk_calm;
            if (snk_stall > 0) begin
                snk_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                snk_stall = pick_gap(snk_calm);
            end
        end
    end

    initial begin
        logic [7:0] cmd [$];
        int         sent_bytes;
        int         sent_cmds;
        clear_model();
        build_directed();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            fill_row(directed_rows[i], cmd);
            send_command(cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        sent_bytes = 0;
        sent_cmds  = 0;
        while (sent_bytes < RANDOM_BYTES || sent_cmds < MIN_COMMANDS) begin
            make_random_command(cmd);
            send_command(cmd, 1'b0, '0);
            sent_bytes += cmd.size();
            sent_cmds++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_decodes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
